/* sv/tcw_pkg.sv */
package tcw_pkg;

  localparam int NUM_COLUMNS = 80;
  localparam int NUM_LINES   = 25;
  localparam int TOTAL_CELLS = NUM_COLUMNS * NUM_LINES;

  // payload field widths
  localparam int REQ_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int IDX_W    = 11;
  localparam int CURSOR_W = 11;

  localparam int ADDR_W  = $clog2(TOTAL_CELLS);
  localparam int NXT_W   = ADDR_W + 1;
  localparam int RD_W    = $clog2(TOTAL_CELLS + NUM_COLUMNS + 1);
  localparam int COL_W   = $clog2(NUM_COLUMNS);
  localparam int RANGE_W = (IDX_W > NXT_W) ? IDX_W : NXT_W;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] FILL_RESET   = 8'h07;

  typedef struct packed {
    logic [CHAR_W-1:0] attr;
    logic [CHAR_W-1:0] glyph;
  } cell_t;

  localparam cell_t RESET_CELL = '{attr: FILL_RESET, glyph: CH_SPACE};

  typedef struct packed {
    logic take;          // item accepted this cycle
    logic fill_wr;       // write blank at sweep, step sweep
    logic fill_init;     // blank uses reset color
    logic scroll_prime;  // first read of the scroll copy
    logic scroll_wr;     // copy or blank at sweep, read ahead, step sweep
    logic load_out;      // load result register
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic past_end;
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage

/* sv/tcw_if.sv */
interface tcw_req_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CHAR_W-1:0] char_code;
  logic [CHAR_W-1:0] char_color;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, req_type, char_code, char_color, cell_index, input ready);
  modport sink   (input valid, req_type, char_code, char_color, cell_index, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CURSOR_W-1:0] cursor_position;
  logic [CHAR_W-1:0]   cell_char;
  logic [CHAR_W-1:0]   cell_attr;

  modport source (output valid, cursor_position, cell_char, cell_attr, input ready);
  modport sink   (input valid, cursor_position, cell_char, cell_attr, output ready);
endinterface

/* sv/tcw_ctrl.sv */
module tcw_ctrl import tcw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_PRIME,
    S_SCROLL,
    S_CLEAR,
    S_FINISH
  } state_t;

  state_t state;

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.fill_wr   = 1'b1;
        cmd.fill_init = 1'b1;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_PRIME:  cmd.scroll_prime = 1'b1;
      S_SCROLL: cmd.scroll_wr    = 1'b1;
      S_CLEAR:  cmd.fill_wr      = 1'b1;
      S_FINISH: cmd.load_out     = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      unique case (state)
        S_INIT: begin
          if (sts.sweep_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            if (sts.is_clear)      state <= S_CLEAR;
            else if (sts.past_end) state <= S_PRIME;
            else                   state <= S_FINISH;
          end
        end
        S_PRIME: state <= S_SCROLL;
        S_SCROLL, S_CLEAR: begin
          if (sts.sweep_last) state <= S_FINISH;
        end
        S_FINISH: begin
          if (sts.out_free) state <= S_IDLE;
        end
        default: state <= S_INIT;
      endcase
    end
  end

endmodule

/* sv/tcw_dp.sv */
module tcw_dp import tcw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic                cfg_we,
  input  logic [CHAR_W-1:0]   cfg_data,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [CHAR_W-1:0]   char_code,
  input  logic [CHAR_W-1:0]   char_color,
  input  logic [IDX_W-1:0]    cell_index,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [CURSOR_W-1:0] cursor_position,
  output logic [CHAR_W-1:0]   cell_char,
  output logic [CHAR_W-1:0]   cell_attr
);

  cell_t mem [TOTAL_CELLS];

  logic [CHAR_W-1:0] fill_color;
  logic [ADDR_W-1:0] cursor;
  logic [COL_W-1:0]  col;
  logic [ADDR_W-1:0] sweep;
  cell_t             rd_data;
  logic              rd_ok;

  logic              is_put, is_read, is_nl, is_bs, in_range, past_end, in_copy;
  logic [NXT_W-1:0]  adv;
  cell_t             blank;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr;
  cell_t             wr_data;
  logic [RD_W-1:0]   rd_addr;

  assign is_put   = (req_type == REQ_PUT);
  assign is_read  = (req_type == REQ_READ);
  assign is_nl    = (char_code == CH_NEWLINE);
  assign is_bs    = (char_code == CH_BACKSPACE);
  assign in_range = RANGE_W'(cell_index) < RANGE_W'(TOTAL_CELLS);
  assign blank    = '{attr: fill_color, glyph: CH_SPACE};
  assign in_copy  = sweep < ADDR_W'(TOTAL_CELLS - NUM_COLUMNS);

  // newline jumps to the start of the next line
  assign adv = is_nl ? ({1'b0, cursor} + NXT_W'(NUM_COLUMNS) - NXT_W'(col))
                     : ({1'b0, cursor} + NXT_W'(1));
  assign past_end = adv >= NXT_W'(TOTAL_CELLS);

  assign sts.is_clear   = (req_type == REQ_CLEAR);
  assign sts.past_end   = is_put && !is_bs && past_end;
  assign sts.sweep_last = (sweep == ADDR_W'(TOTAL_CELLS - 1));
  assign sts.out_free   = !out_valid || out_ready;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cursor;
    wr_data = blank;
    if (cmd.take && is_put && !is_nl) begin
      if (is_bs) begin
        wr_en   = (cursor != '0);
        wr_addr = cursor - ADDR_W'(1);
      end else begin
        wr_en   = 1'b1;
        wr_data = '{attr: char_color, glyph: char_code};
      end
    end
    if (cmd.fill_wr) begin
      wr_en   = 1'b1;
      wr_addr = sweep;
      wr_data = cmd.fill_init ? RESET_CELL : blank;
    end
    if (cmd.scroll_wr) begin
      wr_en   = 1'b1;
      wr_addr = sweep;
      wr_data = in_copy ? rd_data : blank;
    end
  end

  // scroll copy reads one line below, one cell ahead of the write
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.take && is_read && in_range) begin
      rd_en   = 1'b1;
      rd_addr = RD_W'(cell_index);
    end
    if (cmd.scroll_prime) begin
      rd_en   = 1'b1;
      rd_addr = RD_W'(NUM_COLUMNS);
    end
    if (cmd.scroll_wr) begin
      rd_addr = RD_W'(sweep) + RD_W'(NUM_COLUMNS + 1);
      rd_en   = rd_addr < RD_W'(TOTAL_CELLS);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_color <= FILL_RESET;
      cursor     <= '0;
      col        <= '0;
      sweep      <= '0;
      rd_ok      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) fill_color <= cfg_data;

      if (cmd.fill_wr || cmd.scroll_wr) begin
        sweep <= sts.sweep_last ? '0 : sweep + ADDR_W'(1);
      end

      if (cmd.take) begin
        rd_ok <= is_read && in_range;
        if (is_put) begin
          if (is_bs) begin
            if (cursor != '0) begin
              cursor <= cursor - ADDR_W'(1);
              col    <= (col == '0) ? COL_W'(NUM_COLUMNS - 1) : col - COL_W'(1);
            end
          end else if (past_end) begin
            cursor <= ADDR_W'(TOTAL_CELLS - NUM_COLUMNS);
            col    <= '0;
          end else begin
            cursor <= adv[ADDR_W-1:0];
            col    <= (is_nl || col == COL_W'(NUM_COLUMNS - 1)) ? '0 : col + COL_W'(1);
          end
        end else if (sts.is_clear) begin
          cursor <= '0;
          col    <= '0;
        end
      end

      if (cmd.load_out)     out_valid <= 1'b1;
      else if (out_ready)   out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cursor_position <= CURSOR_W'(cursor);
      cell_char       <= rd_ok ? rd_data.glyph : '0;
      cell_attr       <= rd_ok ? rd_data.attr  : '0;
    end
  end

endmodule

/* sv/text_console_writer.sv */
// After accept, put, read and unused requests go to S_FINISH, which loads the
// result register once the output is free.
// No new item is taken until the last result is loaded; the cell read is
// registered between accept and result load.
// A put that scrolls primes the read in S_PRIME, then copies one cell a cycle.
// A clear blanks every cell through the same sweep.
// Reset is synchronous; afterwards a clearing pass over all TOTAL_CELLS (2000)
// cells blanks the grid, with no item accepted meanwhile.
module text_console_writer import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CHAR_W-1:0] cfg_data,
  tcw_req_if.sink           req,
  tcw_rsp_if.source         rsp
);

  cmd_t cmd;
  sts_t sts;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcw_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .req_type        (req.req_type),
    .char_code       (req.char_code),
    .char_color      (req.char_color),
    .cell_index      (req.cell_index),
    .out_ready       (rsp.ready),
    .out_valid       (rsp.valid),
    .cursor_position (rsp.cursor_position),
    .cell_char       (rsp.cell_char),
    .cell_attr       (rsp.cell_attr)
  );

endmodule

/* sv/tcw_checker.sv */
module tcw_checker import tcw_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [CURSOR_W-1:0] rsp_cursor_position,
  input logic [CHAR_W-1:0]   rsp_cell_char,
  input logic [CHAR_W-1:0]   rsp_cell_attr
);

  // items accepted but not yet delivered
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
    end
  end

  a_init_blocks: assert property (@(posedge clk) $past(rst) |-> !req_ready)
    else $error("item taken during clearing pass");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("result without accepted item");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending == 2'd2 |-> !req_ready)
    else $error("more than two items in flight");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_position)
      && $stable(rsp_cell_char) && $stable(rsp_cell_attr))
    else $error("stalled result changed");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk                 (clk),
  .rst                 (rst),
  .req_valid           (req.valid),
  .req_ready           (req.ready),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_cursor_position (rsp.cursor_position),
  .rsp_cell_char       (rsp.cell_char),
  .rsp_cell_attr       (rsp.cell_attr)
);
